// File: sv/dvtu_pkg.sv
// ----------------------------------------------------------------------------
// dvtu_pkg
// Shared types and constants of the distance-vector table update unit.
// ----------------------------------------------------------------------------
package dvtu_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths
  localparam int ADDR_W    = 32;
  localparam int COST_W    = 5;
  localparam int CAND_W    = COST_W + 1;
  localparam int ACT_W     = 3;
  localparam int OUT_IDX_W = 6;
  localparam int CNT_W     = 32;

  // Cost constants
  localparam logic [COST_W-1:0] COST_MAX        = 5'd31;
  localparam logic [COST_W-1:0] HOP_LIMIT_RESET = 5'd16;

  // Result action codes
  localparam logic [ACT_W-1:0] ACT_SAME       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_UPDATED    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERTED   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_OVER_LIMIT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FULL       = 3'd4;

  // Item under work, broadcast to every cell
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] nbr;
    logic [ADDR_W-1:0] ifc;
    logic [CAND_W-1:0] cand;
    logic [COST_W-1:0] cand_sat;
  } item_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic              active;
    logic              found;
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  hit_idx;
    logic [COST_W-1:0] cost;
    logic              free_ok;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  pos;
  } tok_t;

endpackage

// File: sv/dvtu_cell.sv
// ----------------------------------------------------------------------------
// dvtu_cell
// One routing table entry. Evaluates the search token as it passes, updates
// the entry in place on the first match if the route is better or changed,
// notes the first free slot, and takes an insert write when selected.
// ----------------------------------------------------------------------------
module dvtu_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  dvtu_pkg::item_t item,
  input  dvtu_pkg::tok_t  tok_in,
  output dvtu_pkg::tok_t  tok_out,
  input  logic           wr_sel
);

  logic                           valid_r;
  logic [dvtu_pkg::ADDR_W-1:0]    dest_r;
  logic [dvtu_pkg::ADDR_W-1:0]    nh_r;
  logic [dvtu_pkg::ADDR_W-1:0]    ifc_r;
  logic [dvtu_pkg::COST_W-1:0]    cost_r;
  dvtu_pkg::tok_t                 tok_r;
  dvtu_pkg::tok_t                 tok_nxt;
  logic                           upd;
  logic                           hit;
  logic                           changed;

  assign hit     = valid_r && (dest_r == item.dest);
  assign changed = (nh_r != item.nbr) || (ifc_r != item.ifc) ||
                   (cost_r != item.cand_sat);

  // Evaluate the token at this entry
  always_comb begin
    tok_nxt     = tok_in;
    tok_nxt.pos = tok_in.pos + 1'b1;
    upd         = 1'b0;
    if (tok_in.active && !tok_in.found && hit) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.hit_idx = tok_in.pos;
      if (item.kind) begin
        upd            = changed;
        tok_nxt.action = changed ? dvtu_pkg::ACT_UPDATED : dvtu_pkg::ACT_SAME;
        tok_nxt.cost   = item.cand_sat;
      end else if (item.cand < {1'b0, cost_r}) begin
        upd            = 1'b1;
        tok_nxt.action = dvtu_pkg::ACT_UPDATED;
        tok_nxt.cost   = item.cand_sat;
      end else begin
        tok_nxt.action = dvtu_pkg::ACT_SAME;
        tok_nxt.cost   = cost_r;
      end
    end
    if (tok_in.active && !valid_r && !tok_in.free_ok) begin
      tok_nxt.free_ok  = 1'b1;
      tok_nxt.free_idx = tok_in.pos;
    end
  end

  // Advance the token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // Entry valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_sel) begin
      valid_r <= 1'b1;
    end
  end

  // Entry payload: in-place update or insert
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      dest_r <= item.dest;
      nh_r   <= item.nbr;
      ifc_r  <= item.ifc;
      cost_r <= item.cand_sat;
    end else if (upd) begin
      nh_r   <= item.nbr;
      ifc_r  <= item.ifc;
      cost_r <= item.cand_sat;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: sv/distance_vector_table_update_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_table_update_unit
// Routing table update: match, in-place update or insert of advertised and
// direct routes over a chain of table cells.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives exactly one result. From
// acceptance a search token walks the chain of table cells one cell per
// clock, each cell checking its own entry; the token is captured in a
// register as it leaves the chain, and a final step writes an insert and
// loads the output register. in_stall stays high from acceptance until the
// result has been loaded, so the next item can be taken in the cycle after
// that; a result held by out_stall from the previous item delays the final
// step. cfg_ready is always high; the hop limit is sampled at the end of
// the search.
module distance_vector_table_update_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dvtu_pkg::COST_W-1:0]   cfg_max_hop_limit,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [dvtu_pkg::ADDR_W-1:0]   in_dest_addr,
  input  logic [dvtu_pkg::COST_W-1:0]   in_adv_cost,
  input  logic [dvtu_pkg::ADDR_W-1:0]   in_neighbor_addr,
  input  logic [dvtu_pkg::ADDR_W-1:0]   in_recv_iface,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dvtu_pkg::ACT_W-1:0]    out_action,
  output logic [dvtu_pkg::OUT_IDX_W-1:0] out_entry_index,
  output logic [dvtu_pkg::COST_W-1:0]   out_new_cost,
  output logic [dvtu_pkg::CNT_W-1:0]    out_change_tally
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                        state_r;
  logic [1:0]                        state_nxt;
  logic [dvtu_pkg::COST_W-1:0]       limit_r;
  logic [dvtu_pkg::CNT_W-1:0]        cnt_r;
  logic                              start_r;
  dvtu_pkg::item_t                   item_r;
  dvtu_pkg::item_t                   item_nxt;
  dvtu_pkg::tok_t                    res_r;
  dvtu_pkg::tok_t                    tok_head;
  dvtu_pkg::tok_t                    tok_w [dvtu_pkg::TABLE_DEPTH+1];
  logic [dvtu_pkg::TABLE_DEPTH-1:0]  wr_sel;
  logic                              in_fire;
  logic                              fin_fire;
  logic                              fin_ins;
  logic [dvtu_pkg::ACT_W-1:0]        fin_act;
  logic [dvtu_pkg::IDX_W-1:0]        fin_idx;
  logic [dvtu_pkg::COST_W-1:0]       fin_cost;
  logic                              out_valid_r;
  logic [dvtu_pkg::ACT_W-1:0]        out_action_r;
  logic [dvtu_pkg::OUT_IDX_W-1:0]    out_index_r;
  logic [dvtu_pkg::COST_W-1:0]       out_cost_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign fin_fire  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // Hop limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= dvtu_pkg::HOP_LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_max_hop_limit;
    end
  end

  // Form the candidate cost: advertised plus one, or direct as given
  always_comb begin
    item_nxt.kind     = in_kind;
    item_nxt.dest     = in_dest_addr;
    item_nxt.nbr      = in_neighbor_addr;
    item_nxt.ifc      = in_recv_iface;
    item_nxt.cand     = in_kind ? {1'b0, in_adv_cost} : ({1'b0, in_adv_cost} + 6'd1);
    item_nxt.cand_sat = item_nxt.cand[dvtu_pkg::COST_W] ? dvtu_pkg::COST_MAX
                                                        : item_nxt.cand[dvtu_pkg::COST_W-1:0];
  end

  // Hold the item for the whole search
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_nxt;
    end
  end

  // Inject a fresh token into the first cell
  always_comb begin
    tok_head        = '0;
    tok_head.active = start_r;
  end

  assign tok_w[0] = tok_head;

  // Chain of table cells
  for (genvar g = 0; g < dvtu_pkg::TABLE_DEPTH; g++) begin : g_cell
    dvtu_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .item    (item_r),
      .tok_in  (tok_w[g]),
      .tok_out (tok_w[g+1]),
      .wr_sel  (wr_sel[g])
    );
  end

  // Decide the result once the token leaves the chain
  always_comb begin
    fin_ins  = 1'b0;
    fin_act  = dvtu_pkg::ACT_FULL;
    fin_idx  = '0;
    fin_cost = '0;
    if (res_r.found) begin
      fin_act  = res_r.action;
      fin_idx  = res_r.hit_idx;
      fin_cost = res_r.cost;
    end else if (!item_r.kind && (item_r.cand > {1'b0, limit_r})) begin
      fin_act = dvtu_pkg::ACT_OVER_LIMIT;
    end else if (res_r.free_ok) begin
      fin_ins  = 1'b1;
      fin_act  = dvtu_pkg::ACT_INSERTED;
      fin_idx  = res_r.free_idx;
      fin_cost = item_r.cand_sat;
    end
  end

  // Select the free cell for an insert
  always_comb begin
    for (int i = 0; i < dvtu_pkg::TABLE_DEPTH; i++) begin
      wr_sel[i] = fin_fire && fin_ins &&
                  (res_r.free_idx == dvtu_pkg::IDX_W'(i));
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_w[dvtu_pkg::TABLE_DEPTH].active) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_fire;
    end
  end

  // Capture the token as it leaves the last cell
  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && tok_w[dvtu_pkg::TABLE_DEPTH].active) begin
      res_r <= tok_w[dvtu_pkg::TABLE_DEPTH];
    end
  end

  // Change counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (fin_fire && ((fin_act == dvtu_pkg::ACT_UPDATED) ||
                              (fin_act == dvtu_pkg::ACT_INSERTED))) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_action_r <= fin_act;
      out_index_r  <= dvtu_pkg::OUT_IDX_W'(fin_idx);
      out_cost_r   <= fin_cost;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_entry_index  = out_index_r;
  assign out_new_cost     = out_cost_r;
  assign out_change_tally = cnt_r;

endmodule

// File: verif/tb_distance_vector_table_update_unit.sv
// ----------------------------------------------------------------------------
// tb_distance_vector_table_update_unit
// Self-checking bench for the routing table update unit: route items are
// sent with random gaps, every result is checked against a behavioural
// table kept in step with the unit, and the hop limit is changed between
// phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_distance_vector_table_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = dvtu_pkg::TABLE_DEPTH;
  localparam int ADDR_W      = dvtu_pkg::ADDR_W;
  localparam int COST_W      = dvtu_pkg::COST_W;
  localparam int CAND_W      = dvtu_pkg::CAND_W;
  localparam int ACT_W       = dvtu_pkg::ACT_W;
  localparam int OUT_IDX_W   = dvtu_pkg::OUT_IDX_W;
  localparam int CNT_W       = dvtu_pkg::CNT_W;

  localparam int IDLE_LIMIT      = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES    = 80;    // one search plus margin
  localparam int SETTLE_CYCLES   = 4;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int POOL_SIZE       = 56;

  // Directed addresses
  localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [ADDR_W-1:0] NET_C    = 32'h0A00_0300;
  localparam logic [ADDR_W-1:0] NET_D    = 32'h0A00_0400;
  localparam logic [ADDR_W-1:0] NET_E    = 32'h0A00_0500;
  localparam logic [ADDR_W-1:0] NET_F    = 32'h0A00_0600;
  localparam logic [ADDR_W-1:0] NET_G    = 32'h0A00_0700;
  localparam logic [ADDR_W-1:0] NET_H    = 32'h0A00_0800;
  localparam logic [ADDR_W-1:0] HOP_1    = 32'hC0A8_0001;
  localparam logic [ADDR_W-1:0] HOP_2    = 32'hC0A8_0002;
  localparam logic [ADDR_W-1:0] PORT_1   = 32'h0A0A_0001;
  localparam logic [ADDR_W-1:0] PORT_2   = 32'h0A0A_0002;
  localparam logic [ADDR_W-1:0] PORT_3   = 32'h0A0A_0003;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] dest;
    logic [COST_W-1:0] cost;
    logic [ADDR_W-1:0] nbr;
    logic [ADDR_W-1:0] ifc;
  } route_t;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [OUT_IDX_W-1:0] index;
    logic [COST_W-1:0]    cost;
    logic [CNT_W-1:0]     count;
  } route_result_t;

  // --------------------------------------------------------------------------
  // Routing table kept in step with the unit, plus the queue of results due
  // --------------------------------------------------------------------------
  class route_update_checker;
    logic              slot_used [TABLE_DEPTH];
    logic [ADDR_W-1:0] slot_dest [TABLE_DEPTH];
    logic [ADDR_W-1:0] slot_hop  [TABLE_DEPTH];
    logic [ADDR_W-1:0] slot_port [TABLE_DEPTH];
    logic [COST_W-1:0] slot_cost [TABLE_DEPTH];
    logic [COST_W-1:0] hop_limit;
    logic [CNT_W-1:0]  changes;
    route_result_t     expected_updates[$];
    int unsigned       fails;
    int unsigned       n_results;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      hop_limit = dvtu_pkg::HOP_LIMIT_RESET;
      changes   = '0;
      fails     = 0;
      n_results = 0;
    endfunction

    function void set_hop_limit(logic [COST_W-1:0] lim);
      hop_limit = lim;
    endfunction

    // Apply one route to the table and queue the result it should give
    function void note_route(route_t r);
      logic [CAND_W-1:0] cand;
      logic [COST_W-1:0] cand_sat;
      logic              replace;
      int                hit;
      int                free_slot;
      route_result_t     res;
      cand      = r.kind ? {1'b0, r.cost} : {1'b0, r.cost} + 1'b1;
      cand_sat  = (cand > dvtu_pkg::COST_MAX) ? dvtu_pkg::COST_MAX : cand[COST_W-1:0];
      hit       = -1;
      free_slot = -1;
      res       = '0;
      // lowest valid slot holding this destination
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (hit < 0 && slot_used[i] && slot_dest[i] == r.dest) hit = i;
      if (hit >= 0) begin
        if (r.kind) begin
          replace = slot_hop[hit] != r.nbr || slot_port[hit] != r.ifc ||
                    slot_cost[hit] != cand_sat;
        end else begin
          replace = cand < slot_cost[hit];
        end
        if (replace) begin
          slot_hop[hit]  = r.nbr;
          slot_port[hit] = r.ifc;
          slot_cost[hit] = cand_sat;
          res.action     = dvtu_pkg::ACT_UPDATED;
        end else begin
          res.action = dvtu_pkg::ACT_SAME;
        end
        res.index = hit[OUT_IDX_W-1:0];
        res.cost  = slot_cost[hit];
      end else if (!r.kind && cand > hop_limit) begin
        res.action = dvtu_pkg::ACT_OVER_LIMIT;
      end else begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (free_slot < 0 && !slot_used[i]) free_slot = i;
        if (free_slot < 0) begin
          res.action = dvtu_pkg::ACT_FULL;
        end else begin
          slot_used[free_slot] = 1'b1;
          slot_dest[free_slot] = r.dest;
          slot_hop[free_slot]  = r.nbr;
          slot_port[free_slot] = r.ifc;
          slot_cost[free_slot] = cand_sat;
          res.action = dvtu_pkg::ACT_INSERTED;
          res.index  = free_slot[OUT_IDX_W-1:0];
          res.cost   = cand_sat;
        end
      end
      if (res.action == dvtu_pkg::ACT_UPDATED || res.action == dvtu_pkg::ACT_INSERTED)
        changes = changes + 1'b1;
      res.count = changes;
      expected_updates.insert(expected_updates.size(), res);
    endfunction

    task report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fails++;
    endtask

    // Compare one result with the oldest one due
    task check_update(route_result_t got);
      route_result_t want;
      n_results++;
      if (expected_updates.size() == 0) begin
        report_mismatch("result with nothing due", CNT_W'(got.action), '0);
        return;
      end
      want = expected_updates.pop_front();
      if (got.action !== want.action)
        report_mismatch("action", CNT_W'(got.action), CNT_W'(want.action));
      if (got.index !== want.index)
        report_mismatch("entry_index", CNT_W'(got.index), CNT_W'(want.index));
      if (got.cost !== want.cost)
        report_mismatch("new_cost", CNT_W'(got.cost), CNT_W'(want.cost));
      if (got.count !== want.count)
        report_mismatch("change_tally", got.count, want.count);
    endtask

    task report_leftover();
      if (expected_updates.size() != 0)
        report_mismatch("results never delivered", CNT_W'(expected_updates.size()), '0);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and unit
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [COST_W-1:0] cfg_max_hop_limit = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_kind = 1'b0;
  logic [ADDR_W-1:0] in_dest_addr = '0;
  logic [COST_W-1:0] in_adv_cost = '0;
  logic [ADDR_W-1:0] in_neighbor_addr = '0;
  logic [ADDR_W-1:0] in_recv_iface = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ACT_W-1:0]     out_action;
  logic [OUT_IDX_W-1:0] out_entry_index;
  logic [COST_W-1:0]    out_new_cost;
  logic [CNT_W-1:0]     out_change_tally;

  route_update_checker sb;
  logic                quiet = 1'b0;
  int unsigned         n_sent = 0;
  int unsigned         idle_cycles = 0;
  route_t              seen_route;
  route_result_t       seen_result;
  logic [ADDR_W-1:0]   dest_pool [POOL_SIZE];
  logic [ADDR_W-1:0]   hop_pool  [4];
  logic [ADDR_W-1:0]   port_pool [4];
  logic [COST_W-1:0]   phase_limit [4];

  initial begin
    forever #6 clk = ~clk;
  end

  distance_vector_table_update_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_hop_limit (cfg_max_hop_limit),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_dest_addr      (in_dest_addr),
    .in_adv_cost       (in_adv_cost),
    .in_neighbor_addr  (in_neighbor_addr),
    .in_recv_iface     (in_recv_iface),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_entry_index   (out_entry_index),
    .out_new_cost      (out_new_cost),
    .out_change_tally  (out_change_tally)
  );

  // Stall the result side at random, except during the quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 27);
  end

  // Watch all three handshakes; stop the run if none completes for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_hop_limit(cfg_max_hop_limit);
      if (in_valid && !in_stall) begin
        seen_route = '{in_kind, in_dest_addr, in_adv_cost, in_neighbor_addr, in_recv_iface};
        sb.note_route(seen_route);
      end
      if (out_valid && !out_stall) begin
        seen_result = '{out_action, out_entry_index, out_new_cost, out_change_tally};
        sb.check_update(seen_result);
      end
    end
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one route after an optional gap and hold it until taken
  task automatic send_route(input route_t r);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 27)
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 90) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= r.kind;
    in_dest_addr     <= r.dest;
    in_adv_cost      <= r.cost;
    in_neighbor_addr <= r.nbr;
    in_recv_iface    <= r.ifc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // Drop valid and wait until every result sent for has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.n_results < n_sent) @(posedge clk);
  endtask

  task automatic write_hop_limit(input logic [COST_W-1:0] lim);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_max_hop_limit <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly pooled destinations and hops so routes meet again; some fresh ones
  function automatic route_t random_route();
    route_t r;
    r.kind = $urandom_range(0, 99) < 25;
    r.dest = ($urandom_range(0, 99) < 30) ? $urandom() : dest_pool[$urandom_range(0, POOL_SIZE-1)];
    r.cost = $urandom_range(0, 1) ? COST_W'($urandom_range(0, 8))
                                  : COST_W'($urandom_range(0, 31));
    r.nbr  = ($urandom_range(0, 99) < 20) ? $urandom() : hop_pool[$urandom_range(0, 3)];
    r.ifc  = ($urandom_range(0, 99) < 20) ? $urandom() : port_pool[$urandom_range(0, 3)];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    route_t r;
    route_t last_route;
    sb = new();
    foreach (dest_pool[i]) dest_pool[i] = $urandom();
    foreach (hop_pool[i]) hop_pool[i] = $urandom();
    foreach (port_pool[i]) port_pool[i] = $urandom();
    phase_limit[0] = 5'd1;
    phase_limit[1] = COST_W'($urandom_range(2, 30));
    phase_limit[2] = dvtu_pkg::COST_MAX;
    phase_limit[3] = dvtu_pkg::HOP_LIMIT_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset hop limit: insert, keep, limit boundary, cost overflow, direct routes
    send_route(route_t'{1'b0, 32'h0, 5'd0, 32'h0, 32'h0});
    send_route(route_t'{1'b0, 32'h0, 5'd5, HOP_1, PORT_1});
    send_route(route_t'{1'b0, ALL_ONES, 5'd15, ALL_ONES, ALL_ONES});
    send_route(route_t'{1'b0, NET_C, 5'd16, HOP_1, PORT_1});
    send_route(route_t'{1'b0, ALL_ONES, 5'd31, HOP_1, PORT_1});
    send_route(route_t'{1'b1, ALL_ONES, 5'd31, HOP_2, PORT_2});
    send_route(route_t'{1'b0, ALL_ONES, 5'd31, HOP_1, PORT_1});
    send_route(route_t'{1'b0, ALL_ONES, 5'd29, HOP_1, PORT_1});
    send_route(route_t'{1'b1, ALL_ONES, 5'd30, HOP_1, PORT_1});
    send_route(route_t'{1'b1, ALL_ONES, 5'd30, HOP_1, PORT_3});
    send_route(route_t'{1'b1, NET_D, 5'd31, HOP_2, PORT_2});
    send_route(route_t'{1'b1, NET_E, 5'd0, HOP_2, PORT_3});
    send_route(route_t'{1'b0, NET_E, 5'd0, HOP_1, PORT_1});

    // Hop limit zero: advertised routes to new destinations dropped, direct ones still go in
    write_hop_limit(5'd0);
    send_route(route_t'{1'b0, NET_F, 5'd0, HOP_1, PORT_1});
    send_route(route_t'{1'b1, NET_F, 5'd5, HOP_2, PORT_2});
    send_route(route_t'{1'b0, NET_F, 5'd2, HOP_1, PORT_1});

    // Top hop limit: insert at the top cost and overflowing candidates
    write_hop_limit(dvtu_pkg::COST_MAX);
    send_route(route_t'{1'b0, NET_G, 5'd30, HOP_1, PORT_1});
    send_route(route_t'{1'b0, NET_H, 5'd31, HOP_1, PORT_1});
    send_route(route_t'{1'b0, 32'h0, 5'd31, HOP_2, PORT_2});

    // Random phases; the second runs without any idling
    last_route = '0;
    foreach (phase_limit[p]) begin
      write_hop_limit(phase_limit[p]);
      quiet <= (p == 1);
      repeat (ITEMS_PER_PHASE) begin
        r = ($urandom_range(0, 99) < 10) ? last_route : random_route();
        send_route(r);
        last_route = r;
      end
    end
    quiet <= 1'b0;

    // Drain, then allow one more search time for stray results
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.report_leftover();
    if (sb.fails == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
